// ----- rtl/terminal_key_decoder_cursor_macros.svh -----
// Assertion macros shared by the key decoder RTL.
// Each use expects signals named clk and rst in the enclosing module.
`ifndef TERMINAL_KEY_DECODER_CURSOR_MACROS_SVH
`define TERMINAL_KEY_DECODER_CURSOR_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TKD_ASSERT_IMP(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TKD_ASSERT_NXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/tkd_pkg.sv -----
// Package for the terminal key decoder: beat types, key codes and byte constants.
// Used by tkd_parser, tkd_cursor and terminal_key_decoder_cursor.
`default_nettype none
package tkd_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
  } tkd_in_t;

  typedef struct packed {
    logic [8:0] key_code;
    logic       quit_request;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } tkd_out_t;

  typedef struct packed {
    logic       has_key;
    logic [8:0] code;
  } tkd_key_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } tkd_pos_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_BRACKET,
    PH_O,
    PH_SKIP,
    PH_DIGIT
  } tkd_phase_t;

  localparam logic [8:0] K_LEFT  = 9'd256;
  localparam logic [8:0] K_RIGHT = 9'd257;
  localparam logic [8:0] K_UP    = 9'd258;
  localparam logic [8:0] K_DOWN  = 9'd259;
  localparam logic [8:0] K_DEL   = 9'd260;
  localparam logic [8:0] K_HOME  = 9'd261;
  localparam logic [8:0] K_END   = 9'd262;
  localparam logic [8:0] K_PGUP  = 9'd263;
  localparam logic [8:0] K_PGDN  = 9'd264;

  localparam logic [7:0] CTRL_MASK = 8'h1F;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] QUIT_BYTE = 8'h71 & CTRL_MASK;
  localparam logic [8:0] KEY_ESC   = {1'b0, ESC_BYTE};
  localparam logic [8:0] KEY_QUIT  = {1'b0, QUIT_BYTE};

  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_O       = 8'h4F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_THREE   = 8'h33;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_SIX     = 8'h36;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_H       = 8'h48;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [7:0] ROWS_RESET = 8'd24;
  localparam logic [7:0] COLS_RESET = 8'd80;

endpackage
`default_nettype wire

// ----- rtl/terminal_key_decoder_cursor.sv -----
// Top level of the terminal key decoder with its bounded cursor.
// Depends on tkd_pkg, tkd_parser, tkd_cursor and the shared assertion macros.
//
// Accepts one beat per clock while byte_stall is low: a received byte or a
// read-timeout tick. A beat is held in an input register, decoded and applied to
// the cursor in a single pass, and any key it completes is loaded into the result
// register as the beat leaves; sustained throughput is one beat per cycle while
// the result side keeps up, set by the parse and cursor update each beat needs
// before the next can use the state it leaves. Escape bytes and the bytes inside
// a sequence yield no result; a timeout inside a sequence yields a bare ESC.
// Screen size registers (index 0 rows, 1 columns) reset to 24 by 80; the user
// must write them only while the block is idle, which the block does not enforce.
`default_nettype none
`include "terminal_key_decoder_cursor_macros.svh"
module terminal_key_decoder_cursor (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_stall,
  input  wire tkd_pkg::tkd_in_t byte_beat,
  output logic                  key_valid,
  input  wire logic             key_stall,
  output tkd_pkg::tkd_out_t     key_beat,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data
);

  logic              s1_valid;
  tkd_pkg::tkd_in_t  s1_beat;
  logic              out_free, advance, byte_accept;
  logic [7:0]        screen_row_count, screen_col_count;
  tkd_pkg::tkd_key_t key;
  tkd_pkg::tkd_pos_t pos_next;

  assign out_free    = !key_valid || !key_stall;
  assign advance     = s1_valid && out_free;
  assign byte_stall  = s1_valid && !out_free;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_row_count <= tkd_pkg::ROWS_RESET;
      screen_col_count <= tkd_pkg::COLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tkd_pkg::CFG_ROWS: screen_row_count <= cfg_data;
        tkd_pkg::CFG_COLS: screen_col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) s1_beat <= byte_beat;
  end

  tkd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .beat    (s1_beat),
    .key     (key)
  );

  tkd_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .key       (key),
    .row_count (screen_row_count),
    .col_count (screen_col_count),
    .pos_next  (pos_next)
  );

  // Result register: loaded only when the previous beat has gone or is leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= key.has_key;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && key.has_key) begin
      key_beat.key_code     <= key.code;
      key_beat.quit_request <= (key.code == tkd_pkg::KEY_QUIT);
      key_beat.cursor_col   <= pos_next.col;
      key_beat.cursor_row   <= pos_next.row;
    end
  end

  `TKD_ASSERT_IMP(a_quit_matches, key_valid, key_beat.quit_request == (key_beat.key_code == tkd_pkg::KEY_QUIT), "quit flag disagrees with key code")
  `TKD_ASSERT_IMP(a_code_range, key_valid, key_beat.key_code <= tkd_pkg::K_PGDN, "key code out of range")
  `TKD_ASSERT_NXT(a_s1_holds, s1_valid && !advance, s1_valid && $stable(s1_beat), "held input beat was lost")

endmodule
`default_nettype wire

// ----- rtl/tkd_parser.sv -----
// Escape sequence parser: tracks the parse phase and turns bytes into key codes.
// Depends on tkd_pkg and the shared assertion macros.
`default_nettype none
`include "terminal_key_decoder_cursor_macros.svh"
module tkd_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire tkd_pkg::tkd_in_t beat,
  output tkd_pkg::tkd_key_t   key
);

  tkd_pkg::tkd_phase_t phase, phase_next;
  logic [7:0] held_digit, held_digit_next;
  logic       is_digit;

  function automatic logic [8:0] letter_key(input logic [7:0] b, input logic arrows);
    logic [8:0] k;
    k = tkd_pkg::KEY_ESC;
    if (b == tkd_pkg::CH_H) k = tkd_pkg::K_HOME;
    else if (b == tkd_pkg::CH_F) k = tkd_pkg::K_END;
    else if (arrows && b == tkd_pkg::CH_A) k = tkd_pkg::K_UP;
    else if (arrows && b == tkd_pkg::CH_B) k = tkd_pkg::K_DOWN;
    else if (arrows && b == tkd_pkg::CH_C) k = tkd_pkg::K_RIGHT;
    else if (arrows && b == tkd_pkg::CH_D) k = tkd_pkg::K_LEFT;
    return k;
  endfunction

  function automatic logic [8:0] tilde_key(input logic [7:0] d);
    logic [8:0] k;
    unique case (d)
      tkd_pkg::CH_ONE, tkd_pkg::CH_SEVEN:  k = tkd_pkg::K_HOME;
      tkd_pkg::CH_THREE:                   k = tkd_pkg::K_DEL;
      tkd_pkg::CH_FOUR, tkd_pkg::CH_EIGHT: k = tkd_pkg::K_END;
      tkd_pkg::CH_FIVE:                    k = tkd_pkg::K_PGUP;
      tkd_pkg::CH_SIX:                     k = tkd_pkg::K_PGDN;
      default:                             k = tkd_pkg::KEY_ESC;
    endcase
    return k;
  endfunction

  assign is_digit = (beat.byte_in >= tkd_pkg::CH_ZERO) && (beat.byte_in <= tkd_pkg::CH_NINE);

  // Next phase and held digit.
  always_comb begin
    phase_next      = phase;
    held_digit_next = held_digit;
    if (beat.mode) begin
      phase_next = tkd_pkg::PH_IDLE;
    end else begin
      unique case (phase)
        tkd_pkg::PH_IDLE: begin
          if (beat.byte_in == tkd_pkg::ESC_BYTE) phase_next = tkd_pkg::PH_ESC;
        end
        tkd_pkg::PH_ESC: begin
          if (beat.byte_in == tkd_pkg::CH_BRACKET) phase_next = tkd_pkg::PH_BRACKET;
          else if (beat.byte_in == tkd_pkg::CH_O) phase_next = tkd_pkg::PH_O;
          else phase_next = tkd_pkg::PH_SKIP;
        end
        tkd_pkg::PH_BRACKET: begin
          if (is_digit) begin
            phase_next      = tkd_pkg::PH_DIGIT;
            held_digit_next = beat.byte_in;
          end else begin
            phase_next = tkd_pkg::PH_IDLE;
          end
        end
        default: phase_next = tkd_pkg::PH_IDLE;
      endcase
    end
  end

  // Key produced by this beat, if any.
  always_comb begin
    key.has_key = 1'b0;
    key.code    = tkd_pkg::KEY_ESC;
    if (beat.mode) begin
      key.has_key = (phase != tkd_pkg::PH_IDLE);
    end else begin
      unique case (phase)
        tkd_pkg::PH_IDLE: begin
          key.has_key = (beat.byte_in != tkd_pkg::ESC_BYTE);
          key.code    = {1'b0, beat.byte_in};
        end
        tkd_pkg::PH_ESC: key.has_key = 1'b0;
        tkd_pkg::PH_BRACKET: begin
          key.has_key = !is_digit;
          key.code    = letter_key(beat.byte_in, 1'b1);
        end
        tkd_pkg::PH_O: begin
          key.has_key = 1'b1;
          key.code    = letter_key(beat.byte_in, 1'b0);
        end
        tkd_pkg::PH_DIGIT: begin
          key.has_key = 1'b1;
          key.code    = (beat.byte_in == tkd_pkg::CH_TILDE) ? tilde_key(held_digit)
                                                            : tkd_pkg::KEY_ESC;
        end
        default: key.has_key = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tkd_pkg::PH_IDLE;
      held_digit <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

  `TKD_ASSERT_IMP(a_idle_tick_silent, advance && beat.mode && phase == tkd_pkg::PH_IDLE, !key.has_key, "timeout while idle produced a key")
  `TKD_ASSERT_NXT(a_tick_to_idle, advance && beat.mode, phase == tkd_pkg::PH_IDLE, "timeout did not return the parser to idle")
  `TKD_ASSERT_IMP(a_esc_byte_silent, advance && !beat.mode && phase == tkd_pkg::PH_ESC, !key.has_key, "byte after ESC produced a key")

endmodule
`default_nettype wire

// ----- rtl/tkd_cursor.sv -----
// Cursor tracker: moves a cursor inside the screen for each decoded key.
// Depends on tkd_pkg.
`default_nettype none
module tkd_cursor (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire tkd_pkg::tkd_key_t key,
  input  wire logic [7:0]        row_count,
  input  wire logic [7:0]        col_count,
  output tkd_pkg::tkd_pos_t      pos_next
);

  logic [7:0] cursor_x_pos, cursor_y_pos;
  logic [7:0] last_row, last_col;

  assign last_row = (row_count != 8'd0) ? row_count - 8'd1 : 8'd0;
  assign last_col = (col_count != 8'd0) ? col_count - 8'd1 : 8'd0;

  always_comb begin
    pos_next.col = cursor_x_pos;
    pos_next.row = cursor_y_pos;
    unique case (key.code)
      tkd_pkg::K_UP: begin
        if (cursor_y_pos != 8'd0) pos_next.row = cursor_y_pos - 8'd1;
      end
      tkd_pkg::K_DOWN: begin
        if (cursor_y_pos < last_row) pos_next.row = cursor_y_pos + 8'd1;
      end
      tkd_pkg::K_RIGHT: begin
        if (cursor_x_pos < last_col) pos_next.col = cursor_x_pos + 8'd1;
      end
      tkd_pkg::K_LEFT: begin
        if (cursor_x_pos != 8'd0) pos_next.col = cursor_x_pos - 8'd1;
      end
      tkd_pkg::K_HOME: pos_next.col = 8'd0;
      tkd_pkg::K_END:  pos_next.col = last_col;
      tkd_pkg::K_PGUP: begin
        pos_next.row = (cursor_y_pos > row_count) ? cursor_y_pos - row_count : 8'd0;
      end
      tkd_pkg::K_PGDN: begin
        if (cursor_y_pos < last_row) pos_next.row = last_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x_pos <= '0;
      cursor_y_pos <= '0;
    end else if (advance && key.has_key) begin
      cursor_x_pos <= pos_next.col;
      cursor_y_pos <= pos_next.row;
    end
  end

endmodule
`default_nettype wire

// ----- tb/terminal_key_decoder_cursor_test.sv -----
// Self-checking testbench for terminal_key_decoder_cursor.
// It needs tkd_pkg for the beat types, key codes and byte constants, and the RTL
// of the decoder. It has its own decoder and cursor predictor and random stall patterns.
module terminal_key_decoder_cursor_test;
  import tkd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  tkd_in_t byte_beat = '0;
  logic key_valid;
  logic key_stall = 1'b0;
  tkd_out_t key_beat;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_ROWS;
  logic [7:0] cfg_data = 8'd0;

  terminal_key_decoder_cursor DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_beat(byte_beat),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_beat(key_beat),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted decoder state, kept in step with the beats the block accepts.
  tkd_phase_t dec_phase = PH_IDLE;
  logic [7:0] dec_digit = 8'd0;
  logic [7:0] cur_col = 8'd0;
  logic [7:0] cur_row = 8'd0;
  logic [7:0] scr_rows = ROWS_RESET;
  logic [7:0] scr_cols = COLS_RESET;

  tkd_in_t pending_bytes[$];
  tkd_out_t expected_keys[$];
  tkd_out_t predicted_key;
  tkd_out_t wanted_key;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  int unsigned phase_rows [5] = '{24, 255, 2, 0, 1};
  int unsigned phase_cols [5] = '{80, 255, 3, 0, 255};
  int unsigned phase_send [5] = '{0, 48, 0, 8, 48};
  int unsigned phase_stall [5] = '{0, 0, 48, 8, 48};
  int unsigned phase_items [5] = '{300, 350, 350, 200, 400};

  function automatic logic [8:0] letter_code(input logic [7:0] b, input bit arrows);
    if (b == CH_H) return K_HOME;
    if (b == CH_F) return K_END;
    if (arrows) begin
      case (b)
        CH_A: return K_UP;
        CH_B: return K_DOWN;
        CH_C: return K_RIGHT;
        CH_D: return K_LEFT;
        default: ;
      endcase
    end
    return KEY_ESC;
  endfunction

  // Advances the predicted parser and cursor by one beat; returns 1 when a key results.
  function automatic bit advance_decoder(input tkd_in_t beat, output tkd_out_t res);
    logic [8:0] code;
    logic [7:0] b;
    logic [7:0] last_row;
    logic [7:0] last_col;
    bit got;
    b = beat.byte_in;
    got = 1'b0;
    code = '0;
    res = '0;
    if (beat.mode) begin
      if (dec_phase != PH_IDLE) begin
        got = 1'b1;
        code = KEY_ESC;
      end
      dec_phase = PH_IDLE;
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == ESC_BYTE) begin
            dec_phase = PH_ESC;
          end else begin
            got = 1'b1;
            code = {1'b0, b};
          end
        end
        PH_ESC: begin
          dec_phase = (b == CH_BRACKET) ? PH_BRACKET : (b == CH_O) ? PH_O : PH_SKIP;
        end
        PH_BRACKET: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            dec_digit = b;
            dec_phase = PH_DIGIT;
          end else begin
            got = 1'b1;
            code = letter_code(b, 1'b1);
            dec_phase = PH_IDLE;
          end
        end
        PH_O: begin
          got = 1'b1;
          code = letter_code(b, 1'b0);
          dec_phase = PH_IDLE;
        end
        PH_DIGIT: begin
          got = 1'b1;
          code = KEY_ESC;
          if (b == CH_TILDE) begin
            case (dec_digit)
              CH_ONE, CH_SEVEN: code = K_HOME;
              CH_THREE: code = K_DEL;
              CH_FOUR, CH_EIGHT: code = K_END;
              CH_FIVE: code = K_PGUP;
              CH_SIX: code = K_PGDN;
              default: code = KEY_ESC;
            endcase
          end
          dec_phase = PH_IDLE;
        end
        default: begin
          got = 1'b1;
          code = KEY_ESC;
          dec_phase = PH_IDLE;
        end
      endcase
    end
    if (got) begin
      last_row = (scr_rows != 8'd0) ? scr_rows - 8'd1 : 8'd0;
      last_col = (scr_cols != 8'd0) ? scr_cols - 8'd1 : 8'd0;
      case (code)
        K_UP: if (cur_row != 8'd0) cur_row = cur_row - 8'd1;
        K_DOWN: if (cur_row < last_row) cur_row = cur_row + 8'd1;
        K_RIGHT: if (cur_col < last_col) cur_col = cur_col + 8'd1;
        K_LEFT: if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
        K_HOME: cur_col = 8'd0;
        K_END: cur_col = last_col;
        K_PGUP: cur_row = (cur_row > scr_rows) ? cur_row - scr_rows : 8'd0;
        K_PGDN: if (cur_row < last_row) cur_row = last_row;
        default: ;
      endcase
      res.key_code = code;
      res.quit_request = (code == KEY_QUIT);
      res.cursor_col = cur_col;
      res.cursor_row = cur_row;
    end
    return got;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    tkd_in_t item;
    item.mode = 1'b0;
    item.byte_in = b;
    pending_bytes.push_back(item);
    queued_items++;
  endtask

  // The byte field of a timeout beat is ignored, so it carries noise.
  task automatic push_tick();
    tkd_in_t item;
    item.mode = 1'b1;
    item.byte_in = 8'($urandom_range(255));
    pending_bytes.push_back(item);
  endtask

  // Mostly well-formed key sequences, with plain bytes, broken sequences and timeouts mixed in.
  task automatic queue_random_key();
    int unsigned pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      push_byte(8'($urandom_range(255)));
    end else if (pick < 46) begin
      push_byte(ESC_BYTE);
      push_byte(CH_BRACKET);
      case ($urandom_range(3))
        0: push_byte(CH_A);
        1: push_byte(CH_B);
        2: push_byte(CH_C);
        default: push_byte(CH_D);
      endcase
    end else if (pick < 52) begin
      push_byte(ESC_BYTE);
      push_byte(CH_BRACKET);
      push_byte($urandom_range(1) ? CH_H : CH_F);
    end else if (pick < 57) begin
      push_byte(ESC_BYTE);
      push_byte(CH_O);
      push_byte($urandom_range(1) ? CH_H : CH_F);
    end else if (pick < 70) begin
      push_byte(ESC_BYTE);
      push_byte(CH_BRACKET);
      case ($urandom_range(6))
        0: push_byte(CH_ONE);
        1: push_byte(CH_THREE);
        2: push_byte(CH_FOUR);
        3: push_byte(CH_FIVE);
        4: push_byte(CH_SIX);
        5: push_byte(CH_SEVEN);
        default: push_byte(CH_EIGHT);
      endcase
      push_byte(CH_TILDE);
    end else if (pick < 76) begin
      push_byte(ESC_BYTE);
      push_byte(CH_BRACKET);
      b = $urandom_range(1) ? CH_ZERO + 8'($urandom_range(9)) : 8'($urandom_range(255));
      push_byte(b);
      if (b >= CH_ZERO && b <= CH_NINE)
        push_byte($urandom_range(1) ? CH_TILDE : 8'($urandom_range(255)));
    end else if (pick < 82) begin
      push_byte(ESC_BYTE);
      push_byte(8'($urandom_range(255)));
      push_byte(8'($urandom_range(255)));
    end else if (pick < 89) begin
      push_byte(ESC_BYTE);
      if ($urandom_range(1)) begin
        push_byte(CH_BRACKET);
        if ($urandom_range(1)) push_byte(CH_ZERO + 8'($urandom_range(9)));
      end
      push_tick();
    end else if (pick < 93) begin
      push_tick();
    end else begin
      push_byte(ESC_BYTE);
      push_byte(CH_O);
      push_byte(8'($urandom_range(255)));
    end
  endtask

  // Holds the sender back until every beat is taken and every key has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || byte_valid || expected_keys.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_screen(input logic [7:0] rows, input logic [7:0] cols);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_write <= 1'b0;
    scr_rows = rows;
    scr_cols = cols;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: the prediction for a beat is made at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (byte_valid) begin
        if (advance_decoder(byte_beat, predicted_key)) expected_keys.push_back(predicted_key);
      end
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_valid <= 1'b1;
        byte_beat <= pending_bytes.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      key_stall <= 1'b0;
    end else begin
      key_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each key beat taken is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && key_valid && !key_stall) begin
      if (expected_keys.size() == 0) begin
        mismatches++;
        $display("%0t: key beat expected none actual key_code %0d col %0d row %0d",
                 $time, key_beat.key_code, key_beat.cursor_col, key_beat.cursor_row);
      end else begin
        wanted_key = expected_keys.pop_front();
        check_field("key_code", wanted_key.key_code, key_beat.key_code);
        check_field("quit_request", 9'(wanted_key.quit_request), 9'(key_beat.quit_request));
        check_field("cursor_col", 9'(wanted_key.cursor_col), 9'(key_beat.cursor_col));
        check_field("cursor_row", 9'(wanted_key.cursor_row), 9'(key_beat.cursor_row));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("terminal_key_decoder_cursor: mismatch");
    $finish;
  end

  initial begin
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Byte extremes, Ctrl-Q, and a timeout while idle, which gives nothing.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(QUIT_BYTE);
    push_tick();
    // A timeout inside a sequence gives a bare ESC.
    push_byte(ESC_BYTE); push_tick();
    // Up at the top row stays put, then right, down and end of line.
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_A);
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_C);
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_B);
    push_byte(ESC_BYTE); push_byte(CH_O); push_byte(CH_F);
    // Page down, page up and delete.
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_SIX); push_byte(CH_TILDE);
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_FIVE); push_byte(CH_TILDE);
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_THREE); push_byte(CH_TILDE);
    // A digit without its tilde, and an unknown byte after ESC that swallows the next.
    push_byte(ESC_BYTE); push_byte(CH_BRACKET); push_byte(CH_ZERO + 8'd2); push_byte(8'h78);
    push_byte(ESC_BYTE); push_byte(8'h7A); push_byte(8'h7A);

    for (phase = 0; phase < 5; phase++) begin
      if (phase != 0) begin
        wait_for_drain();
        write_screen(8'(phase_rows[phase]), 8'(phase_cols[phase]));
        @(negedge clk);
      end
      send_idle_pct = phase_send[phase];
      stall_pct = phase_stall[phase];
      queued_items = 0;
      while (queued_items < phase_items[phase]) queue_random_key();
    end

    wait_for_drain();
    if (mismatches == 0) begin
      $display("terminal_key_decoder_cursor: match");
    end else begin
      $display("terminal_key_decoder_cursor: mismatch");
    end
    $finish;
  end

endmodule
